// ----- hw/rtl/slcd_pkg.sv -----
// Shared types and constants of the serial line command decoder.
`default_nettype none

package slcd_pkg;

    // Line store geometry
    localparam int LINE_DEPTH = 32;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_O  = 8'h4F;
    localparam logic [7:0] CH_UP_N  = 8'h4E;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    // Speed limits
    localparam logic [15:0] MAG_LIMIT = 16'd32768;
    localparam logic [15:0] SPEED_MAX = 16'd32767;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_ERASE,
        OP_LF,
        OP_CR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_ON    = 3'd1,
        CMD_OFF   = 3'd2,
        CMD_SPEED = 3'd3,
        CMD_BAD   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [7:0]         echo;
        t_cmd               cmd;
        logic signed [15:0] speed;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/slcd_front.sv -----
// Front end: accepts received characters and classifies them for the queue.
`default_nettype none

module slcd_front
    import slcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_char
    input  wire logic       i_q_full,
    output t_push           o_push
);

    t_op w_op;

    // Classify the character
    always_comb begin
        unique case (i_s_tdata) inside
            CH_CR:         w_op = OP_CR;
            CH_BS, CH_DEL: w_op = OP_ERASE;
            CH_LF:         w_op = OP_LF;
            default:       w_op = OP_APPEND;
        endcase
    end

    // Accept whenever the queue has room; drop the NUL character
    assign o_s_tready     = ~i_q_full;
    assign o_push.valid   = i_s_tvalid & ~i_q_full & (i_s_tdata != CH_NUL);
    assign o_push.item.op = w_op;
    assign o_push.item.ch = i_s_tdata;

    logic unused_clk;
    assign unused_clk = i_clk;

endmodule

`default_nettype wire

// ----- hw/rtl/slcd_queue.sv -----
// Short queue of classified characters between front and back.
`default_nettype none

module slcd_queue
    import slcd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               w_do_push, w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_entry[r_rd_ptr];
    assign w_do_push = i_push.valid & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold entry payload
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_entry[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/slcd_exec.sv -----
// Back end: line store, line decode sequencer and output register.
`default_nettype none

module slcd_exec
    import slcd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  wire logic  i_m_tready,
    output t_result    o_result
);

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_on_ok, n_on_ok;
    logic              r_off_ok, n_off_ok;
    logic              r_spd_ok, n_spd_ok;
    logic              r_neg, n_neg;
    logic [15:0]       r_mag, n_mag;
    logic [7:0]        r_echo, n_echo;

    logic [7:0]        r_line_store [LINE_DEPTH];
    logic [7:0]        r_rd_data;
    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_mem_we;

    logic              r_out_valid;
    t_result           r_out;
    logic              w_load;
    t_result           w_load_data;

    logic              w_slot_free;
    logic              w_is_last;
    logic              w_start_scan;
    logic              w_on_char, w_off_char, w_is_digit;
    logic [7:0]        w_digit;
    logic [18:0]       w_mag_next;
    logic [15:0]       w_speed;
    t_cmd              w_cmd;

    assign w_slot_free = ~r_out_valid | i_m_tready;
    assign w_is_last   = (LEN_W'(r_idx) == r_len - LEN_W'(1));
    assign w_start_scan = i_q_valid && w_slot_free && (i_q_item.op == OP_CR) &&
                          !r_ovf && (r_len != '0);

    // Per-character checks of the scanned line
    assign w_on_char  = ((r_idx == IDX_W'(0)) && (r_rd_data == CH_UP_O)) ||
                        ((r_idx == IDX_W'(1)) && (r_rd_data == CH_UP_N));
    assign w_off_char = ((r_idx == IDX_W'(0)) && (r_rd_data == CH_UP_O)) ||
                        ((r_idx == IDX_W'(1)) && (r_rd_data == CH_UP_F)) ||
                        ((r_idx == IDX_W'(2)) && (r_rd_data == CH_UP_F));
    assign w_is_digit = (r_rd_data >= CH_ZERO) && (r_rd_data <= CH_NINE);
    assign w_digit    = r_rd_data - CH_ZERO;
    assign w_mag_next = (19'(r_mag) << 3) + (19'(r_mag) << 1) + 19'(w_digit[3:0]);

    // Final speed value and command of the scanned line
    assign w_speed = r_neg ? 16'(17'd0 - 17'(r_mag)) :
                     ((r_mag > SPEED_MAX) ? SPEED_MAX : r_mag);
    always_comb begin
        if (r_on_ok) begin
            w_cmd = CMD_ON;
        end else if (r_off_ok) begin
            w_cmd = CMD_OFF;
        end else if (r_spd_ok) begin
            w_cmd = CMD_SPEED;
        end else begin
            w_cmd = CMD_BAD;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_is_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_on_ok     = r_on_ok;
        n_off_ok    = r_off_ok;
        n_spd_ok    = r_spd_ok;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_echo      = r_echo;
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;
        w_rd_addr   = '0;
        w_load      = 1'b0;
        w_load_data = '{echo: i_q_item.ch, cmd: CMD_NONE, speed: '0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_slot_free) begin
                    o_pop = 1'b1;
                    unique case (i_q_item.op)
                        OP_APPEND: begin
                            w_load = 1'b1;
                            if (r_len < LEN_W'(LINE_DEPTH)) begin
                                w_mem_we = 1'b1;
                                n_len    = r_len + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            w_load           = 1'b1;
                            w_load_data.echo = CH_DEL;
                            if (r_len != '0) begin
                                n_len = r_len - 1'b1;
                            end
                        end
                        OP_LF: begin
                            w_load = 1'b1;
                        end
                        OP_CR: begin
                            if (r_ovf) begin
                                w_load          = 1'b1;
                                w_load_data.cmd = CMD_BAD;
                                n_len           = '0;
                                n_ovf           = 1'b0;
                            end else if (r_len == '0) begin
                                w_load = 1'b1;
                            end else begin
                                // Start the scan at the first stored character
                                n_echo   = i_q_item.ch;
                                n_idx    = '0;
                                n_on_ok  = (r_len == LEN_W'(2));
                                n_off_ok = (r_len == LEN_W'(3));
                                n_spd_ok = 1'b1;
                                n_neg    = 1'b0;
                                n_mag    = '0;
                            end
                        end
                        default: w_load = 1'b0;
                    endcase
                end
            end
            ST_SCAN: begin
                w_rd_addr = r_idx + 1'b1;
                n_idx     = r_idx + 1'b1;
                n_on_ok   = r_on_ok & w_on_char;
                n_off_ok  = r_off_ok & w_off_char;
                if (w_is_last) begin
                    if (r_rd_data != CH_PCT) begin
                        n_spd_ok = 1'b0;
                    end
                end else if ((r_idx == '0) && (r_rd_data == CH_MINUS)) begin
                    n_neg = 1'b1;
                end else if (!w_is_digit) begin
                    n_spd_ok = 1'b0;
                end else begin
                    n_mag = (w_mag_next > 19'(MAG_LIMIT)) ? MAG_LIMIT : w_mag_next[15:0];
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    w_load            = 1'b1;
                    w_load_data.echo  = r_echo;
                    w_load_data.cmd   = w_cmd;
                    w_load_data.speed = (w_cmd == CMD_SPEED) ? w_speed : '0;
                    n_len             = '0;
                    n_ovf             = 1'b0;
                end
            end
            default: w_load = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan and result payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_on_ok  <= n_on_ok;
        r_off_ok <= n_off_ok;
        r_spd_ok <= n_spd_ok;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_echo   <= n_echo;
        if (w_load) begin
            r_out <= w_load_data;
        end
    end

    // Line store: write on append, registered read for the scan
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_line_store[r_len[IDX_W-1:0]] <= i_q_item.ch;
        end
        r_rd_data <= r_line_store[w_rd_addr];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/serial_line_command_decoder_top.sv -----
// Top level of the serial line command decoder.
//
//  Channel   Direction  tdata                               tuser
//  s_axis    in         [7:0] rx_char                       -
//  m_axis    out        [7:0] echo_char, [23:8] speed_value [2:0] command
//
// An ordinary character passes the queue and then the output register on its way
// from transfer in to result out. A CR over a stored line of up to 32 characters
// is answered after the scan that reads the line store one character a cycle.
// Up to four characters wait in the queue while the back end scans or stalls.
// Reset is synchronous; the line store needs no clearing pass.
`default_nettype none

module serial_line_command_decoder_top
    import slcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_char
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] echo_char, [23:8] speed_value
    output logic [2:0]       o_m_tuser    // [2:0] command
);

    t_push   w_push;
    logic    w_q_full;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_result;

    slcd_front u_front (
        .i_clk      (i_clk),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (w_q_full),
        .o_push     (w_push)
    );

    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    slcd_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (w_result)
    );

    // Pack the result fields onto the stream
    assign o_m_tdata = {w_result.speed, w_result.echo};
    assign o_m_tuser = w_result.cmd;

endmodule

`default_nettype wire

// ----- hw/rtl/slcd_checker.sv -----
// Port-level checks of the serial line command decoder, bound to the top level.
`default_nettype none

module slcd_checker
    import slcd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [7:0]  i_s_tdata,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic [2:0]  o_m_tuser
);

    // A command only ever comes with an echoed CR
    a_cmd_on_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != CMD_NONE)) |-> (o_m_tdata[7:0] == CH_CR))
        else $error("command on a result that does not echo CR");

    // A nonzero speed belongs to a speed command
    a_speed_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[23:8] != 16'd0)) |-> (o_m_tuser == CMD_SPEED))
        else $error("speed value on a non-speed command");

    // Backspace is echoed as DEL and NUL never gives a result
    a_echo_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[7:0] != CH_BS) && (o_m_tdata[7:0] != CH_NUL)))
        else $error("echo of backspace or NUL");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    logic unused_in;
    assign unused_in = i_s_tvalid ^ o_s_tready ^ (^i_s_tdata);

endmodule

bind serial_line_command_decoder_top slcd_checker u_slcd_checker (.*);

`default_nettype wire
